// ----- sv/epoch_seconds_to_calendar_macros.svh -----
// Assertion macros for the epoch seconds to calendar block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ESC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/esc_pkg.sv -----
// Shared types and constants for the epoch seconds to calendar block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package esc_pkg;

    localparam int TIME_W = 32;
    localparam int ZONE_W = 14;

    localparam logic signed [ZONE_W-1:0] OFFSET_LIMIT = 14'sd780;

    // Reciprocals for constant division: floor(2^k / divisor)
    localparam logic [22:0] DAY_RECIP  = 23'd6362914;   // 2^32 / 675
    localparam logic [12:0] HOUR_RECIP = 13'd4660;      // 2^24 / 3600
    localparam logic [17:0] WEEK_RECIP = 18'd149796;    // 2^20 / 7
    localparam logic [15:0] QUAD_RECIP = 16'd45933;     // 2^26 / 1461
    localparam logic [12:0] MIN_RECIP  = 13'd4369;      // 2^18 / 60

    localparam logic [9:0]  DAY_DIV   = 10'd675;        // 86400 / 128
    localparam logic [11:0] HOUR_DIV  = 12'd3600;
    localparam logic [2:0]  WEEK_DIV  = 3'd7;
    localparam logic [10:0] QUAD_DIV  = 11'd1461;
    localparam logic [5:0]  MIN_DIV   = 6'd60;
    localparam logic [15:0] EPOCH_TO_1968 = 16'd731;
    localparam logic [15:0] THURSDAY_ADJ  = 16'd4;
    localparam logic [7:0]  BASE_YEAR     = 8'd68;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        want_local;
    } t_esc_in;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
    } t_esc_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DAYMUL,
        B_DAYREM,
        B_DAYFIX,
        B_SPLITMUL,
        B_SPLITREM,
        B_SPLITFIX,
        B_MINMUL,
        B_MINREM,
        B_FIN
    } t_back_state;

    // First day of a month within the year, leap years shifted after February
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && m >= 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ----- sv/esc_queue.sv -----
// Small register queue between front and back of the calendar converter.
// Depends on esc_pkg for the status struct.
`timescale 1ns / 1ps

module esc_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_rdata,
    output esc_pkg::t_q_stat     o_stat
);
    import esc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- sv/esc_front.sv -----
// Front end: zone register, command handshake and local time adjustment.
// Depends on esc_pkg; feeds the queue with adjusted second counts.
`timescale 1ns / 1ps

module esc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  esc_pkg::t_esc_in            i_in,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic signed [esc_pkg::ZONE_W-1:0] i_cfg_wdata,
    input  esc_pkg::t_q_stat            i_stat,
    output logic                        o_push,
    output logic [esc_pkg::TIME_W-1:0]  o_push_data
);
    import esc_pkg::*;

    logic signed [ZONE_W-1:0] r_zone;
    logic                     r_vld;
    logic                     n_vld;
    logic [TIME_W-1:0]        r_t;
    logic                     w_accept;
    logic                     w_zone_ok;
    logic signed [16:0]       w_adj17;
    logic [TIME_W-1:0]        w_adj;
    logic [TIME_W-1:0]        w_t;

    assign o_busy      = r_vld && i_stat.full;
    assign w_accept    = i_start && !o_busy;
    assign o_push      = r_vld;
    assign o_push_data = r_t;

    // Offsets of thirteen hours or more act as zero
    assign w_zone_ok = (r_zone > -OFFSET_LIMIT) && (r_zone < OFFSET_LIMIT);
    assign w_adj17   = 17'(r_zone) * 17'sd60;
    assign w_adj     = (i_in.want_local && w_zone_ok) ?
                       {{(TIME_W - 17){w_adj17[16]}}, w_adj17} : '0;
    assign w_t       = i_in.epoch_seconds + w_adj;

    // Hold the word while the queue is full
    assign n_vld = w_accept || (r_vld && i_stat.full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_zone <= i_cfg_wdata;
            end
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t <= w_t;
        end
    end

endmodule

// ----- sv/esc_back.sv -----
// Back end: sequencer that splits a second count into calendar fields.
// Depends on esc_pkg; divisions by constants use reciprocal multiply and one fix-up.
`timescale 1ns / 1ps

module esc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  esc_pkg::t_q_stat            i_stat,
    input  logic [esc_pkg::TIME_W-1:0]  i_data,
    output logic                        o_pop,
    output logic                        o_idle,
    output logic                        o_valid,
    output esc_pkg::t_esc_out           o_out
);
    import esc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [TIME_W-1:0] r_t;
    logic [47:0]       r_pday;
    logic [15:0]       r_days;
    logic [10:0]       r_drem;
    logic [16:0]       r_secs;
    logic [28:0]       r_ph;
    logic [33:0]       r_pw;
    logic [31:0]       r_pq;
    logic [4:0]        r_hour;
    logic [12:0]       r_hrem;
    logic [3:0]        r_wrem;
    logic [2:0]        r_wday;
    logic [5:0]        r_quads;
    logic [11:0]       r_qrem;
    logic [23:0]       r_pm;
    logic [7:0]        r_year;
    logic [8:0]        r_yday;
    logic              r_leap;
    logic [5:0]        r_min;
    logic [6:0]        r_srem;
    logic [3:0]        r_month;
    logic [4:0]        r_mday;
    t_esc_out          r_out;
    logic              r_valid;

    logic              w_emit;
    logic [15:0]       w_dq;
    logic [10:0]       w_drem;
    logic [15:0]       w_days4;
    logic [15:0]       w_days731;
    logic [4:0]        w_hq;
    logic [12:0]       w_hrem;
    logic [13:0]       w_wq;
    logic [3:0]        w_wrem;
    logic [5:0]        w_qq;
    logic [11:0]       w_qrem;
    logic [1:0]        w_yoff;
    logic [8:0]        w_yday;
    logic [5:0]        w_mq;
    logic [6:0]        w_srem;
    logic [3:0]        w_month;
    logic [8:0]        w_mstart;
    logic [4:0]        w_mday;
    t_esc_out          w_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:     if (!i_stat.empty) begin
                            n_state = B_DAYMUL;
                        end
            B_DAYMUL:   n_state = B_DAYREM;
            B_DAYREM:   n_state = B_DAYFIX;
            B_DAYFIX:   n_state = B_SPLITMUL;
            B_SPLITMUL: n_state = B_SPLITREM;
            B_SPLITREM: n_state = B_SPLITFIX;
            B_SPLITFIX: n_state = B_MINMUL;
            B_MINMUL:   n_state = B_MINREM;
            B_MINREM:   n_state = B_FIN;
            B_FIN:      n_state = B_IDLE;
            default:    n_state = B_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop  = 1'b0;
        o_idle = 1'b0;
        w_emit = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_pop  = !i_stat.empty;
                o_idle = 1'b1;
            end
            B_FIN:   w_emit = 1'b1;
            default: w_emit = 1'b0;
        endcase
    end

    // Quotient estimates are low by at most one; remainders fit the narrow widths
    assign w_dq      = r_pday[47:32];
    assign w_drem    = 11'(25'(r_t[31:7]) - 25'(w_dq) * 25'(DAY_DIV));
    assign w_days4   = r_days + THURSDAY_ADJ;
    assign w_days731 = r_days + EPOCH_TO_1968;
    assign w_hq      = r_ph[28:24];
    assign w_hrem    = 13'(r_secs - 17'(w_hq) * 17'(HOUR_DIV));
    assign w_wq      = r_pw[33:20];
    assign w_wrem    = 4'(w_days4 - 16'(w_wq) * 16'(WEEK_DIV));
    assign w_qq      = r_pq[31:26];
    assign w_qrem    = 12'(w_days731 - 16'(w_qq) * 16'(QUAD_DIV));
    assign w_mq      = r_pm[23:18];
    assign w_srem    = 7'(r_hrem[11:0] - 12'(w_mq) * 12'(MIN_DIV));

    // Place the day within a four-year group starting on a leap year
    always_comb begin
        if (r_qrem < 12'd366) begin
            w_yoff = 2'd0;
            w_yday = 9'(r_qrem);
        end else if (r_qrem < 12'd731) begin
            w_yoff = 2'd1;
            w_yday = 9'(r_qrem - 12'd366);
        end else if (r_qrem < 12'd1096) begin
            w_yoff = 2'd2;
            w_yday = 9'(r_qrem - 12'd731);
        end else begin
            w_yoff = 2'd3;
            w_yday = 9'(r_qrem - 12'd1096);
        end
    end

    always_comb begin
        logic [8:0] s;
        s        = '0;
        w_month  = '0;
        w_mstart = '0;
        for (int m = 1; m < 12; m++) begin
            s = month_start(4'(m), r_leap);
            if (r_yday >= s) begin
                w_month  = 4'(m);
                w_mstart = s;
            end
        end
        w_mday = 5'(r_yday - w_mstart + 9'd1);
    end

    always_comb begin
        w_out.second           = (r_srem >= 7'(MIN_DIV)) ? 6'(r_srem - 7'(MIN_DIV))
                                                         : 6'(r_srem);
        w_out.minute           = (r_srem >= 7'(MIN_DIV)) ? r_min + 6'd1 : r_min;
        w_out.hour             = r_hour;
        w_out.day_of_month     = r_mday;
        w_out.month_index      = r_month;
        w_out.years_since_1900 = r_year;
        w_out.weekday          = r_wday;
        w_out.day_of_year      = r_yday;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_t <= i_data;
                end
            end
            B_DAYMUL: begin
                r_pday <= 48'(r_t[31:7]) * 48'(DAY_RECIP);
            end
            B_DAYREM: begin
                r_days <= w_dq;
                r_drem <= w_drem;
            end
            B_DAYFIX: begin
                if (r_drem >= 11'(DAY_DIV)) begin
                    r_days <= r_days + 16'd1;
                    r_secs <= {10'(r_drem - 11'(DAY_DIV)), r_t[6:0]};
                end else begin
                    r_secs <= {10'(r_drem), r_t[6:0]};
                end
            end
            B_SPLITMUL: begin
                r_ph <= 29'(r_secs) * 29'(HOUR_RECIP);
                r_pw <= 34'(w_days4) * 34'(WEEK_RECIP);
                r_pq <= 32'(w_days731) * 32'(QUAD_RECIP);
            end
            B_SPLITREM: begin
                r_hour  <= w_hq;
                r_hrem  <= w_hrem;
                r_wrem  <= w_wrem;
                r_quads <= w_qq;
                r_qrem  <= w_qrem;
            end
            B_SPLITFIX: begin
                if (r_hrem >= 13'(HOUR_DIV)) begin
                    r_hour <= r_hour + 5'd1;
                    r_hrem <= r_hrem - 13'(HOUR_DIV);
                end
                r_wday <= (r_wrem >= 4'(WEEK_DIV)) ? 3'(r_wrem - 4'(WEEK_DIV))
                                                   : 3'(r_wrem);
                if (r_qrem >= 12'(QUAD_DIV)) begin
                    r_quads <= r_quads + 6'd1;
                    r_qrem  <= r_qrem - 12'(QUAD_DIV);
                end
            end
            B_MINMUL: begin
                r_pm   <= 24'(r_hrem[11:0]) * 24'(MIN_RECIP);
                r_yday <= w_yday;
                r_leap <= (w_yoff == 2'd0);
                r_year <= BASE_YEAR + {r_quads, 2'b00} + 8'(w_yoff);
            end
            B_MINREM: begin
                r_min   <= w_mq;
                r_srem  <= w_srem;
                r_month <= w_month;
                r_mday  <= w_mday;
            end
            B_FIN: begin
                r_out <= w_out;
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ----- sv/epoch_seconds_to_calendar.sv -----
// Converts 32-bit epoch second counts to broken-down calendar time.
// Depends on esc_pkg, esc_front, esc_queue, esc_back and the assertion macro header.
//
// A command word is taken at a clock edge with start high and busy low; busy
// rises only when the front register and the queue behind it are both full.
// The back sequencer pops a word in its idle state and then runs nine steps
// (day multiply, remainder, fix-up; split multiply, remainder, fix-up; minute
// multiply, remainder; finish), popping no new word until it is back in idle.
// Each result sits on o_out for exactly one clock with o_valid high
// and cannot be held off by the receiver. The zone offset is sampled when a
// word is taken, so write it only while no word is in flight.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  esc_pkg::t_esc_in                   i_in,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic signed [esc_pkg::ZONE_W-1:0]  i_cfg_wdata,
    output logic                               o_valid,
    output esc_pkg::t_esc_out                  o_out
);
    import esc_pkg::*;

    `include "epoch_seconds_to_calendar_macros.svh"

    t_q_stat           q_stat;
    logic              front_push;
    logic [TIME_W-1:0] front_data;
    logic              back_pop;
    logic              back_idle;
    logic [TIME_W-1:0] q_data;
    logic              w_fields_ok;
    logic              w_quiet;

    esc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_in        (i_in),
        .o_busy      (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (q_stat),
        .o_push      (front_push),
        .o_push_data (front_data)
    );

    esc_queue #(
        .WIDTH (TIME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_data),
        .i_pop   (back_pop),
        .o_rdata (q_data),
        .o_stat  (q_stat)
    );

    esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_data  (q_data),
        .o_pop   (back_pop),
        .o_idle  (back_idle),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    assign w_fields_ok = (o_out.second < 6'd60) && (o_out.minute < 6'd60) &&
                         (o_out.hour < 5'd24) && (o_out.month_index < 4'd12) &&
                         (o_out.day_of_month != 5'd0) && (o_out.weekday < 3'd7);
    assign w_quiet     = q_stat.empty && !front_push && back_idle;

    `ESC_ASSERT_SAME(a_fields_in_range, o_valid, w_fields_ok, "calendar field out of range")
    `ESC_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobes on consecutive cycles")
    `ESC_ASSERT_NEXT(a_no_phantom, w_quiet, !o_valid, "result with no word in flight")

endmodule

// ----- tb/sv/tb_epoch_seconds_to_calendar.sv -----
// Self-checking bench for epoch_seconds_to_calendar: drives second counts and
// zone offsets and compares each calendar word with an in-bench predictor.
// Depends on esc_pkg and the epoch_seconds_to_calendar top level.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;
    import esc_pkg::*;

    localparam int          ZONE_LIMIT     = 780;
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned DAYS_PER_QUAD  = 1461;
    localparam int unsigned DAYS_1968_1970 = 731;
    localparam int unsigned MAX_DAY        = 49710;
    localparam int          IDLE_PCT       = 31;
    localparam int          SETTLE_CYCLES  = 20;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    t_esc_in                  i_in        = '0;
    logic                     busy;
    logic                     i_cfg_we    = 1'b0;
    logic signed [ZONE_W-1:0] i_cfg_wdata = '0;
    logic                     o_valid;
    t_esc_out                 o_out;

    class calendar_scoreboard;
        t_esc_out                 pending_dates[$];
        logic signed [ZONE_W-1:0] zone_minutes;
        int unsigned              errors;

        function new();
            zone_minutes = '0;
            errors       = 0;
        endfunction

        function int unsigned month_first(int unsigned m, bit leap);
            int unsigned s;
            case (m)
                0:       s = 0;
                1:       s = 31;
                2:       s = 59;
                3:       s = 90;
                4:       s = 120;
                5:       s = 151;
                6:       s = 181;
                7:       s = 212;
                8:       s = 243;
                9:       s = 273;
                10:      s = 304;
                default: s = 334;
            endcase
            if (leap && m >= 2) begin
                s = s + 1;
            end
            return s;
        endfunction

        function t_esc_out calendar_of(t_esc_in w);
            int          offset;
            int unsigned t, days, secs, d, quads, r, yoff, yday, month;
            bit          leap;
            t_esc_out    cal;
            offset = int'(zone_minutes);
            // Treat out-of-range offsets as UTC
            if (offset <= -ZONE_LIMIT || offset >= ZONE_LIMIT) begin
                offset = 0;
            end
            t = w.epoch_seconds;
            if (w.want_local) begin
                t = t + unsigned'(offset * 60);
            end
            days  = t / SECS_PER_DAY;
            secs  = t % SECS_PER_DAY;
            // Count from 1968, the leap year that opens a four-year group
            d     = days + DAYS_1968_1970;
            quads = d / DAYS_PER_QUAD;
            r     = d % DAYS_PER_QUAD;
            if (r < 366) begin
                yoff = 0;
                yday = r;
            end else begin
                r    = r - 366;
                yoff = 1 + r / 365;
                yday = r % 365;
            end
            leap  = (yoff == 0);
            month = 0;
            for (int unsigned m = 1; m < 12; m++) begin
                if (yday >= month_first(m, leap)) begin
                    month = m;
                end
            end
            cal.second           = 6'((secs % SECS_PER_HOUR) % 60);
            cal.minute           = 6'((secs % SECS_PER_HOUR) / 60);
            cal.hour             = 5'(secs / SECS_PER_HOUR);
            cal.day_of_month     = 5'(yday - month_first(month, leap) + 1);
            cal.month_index      = 4'(month);
            cal.years_since_1900 = 8'(68 + 4 * quads + yoff);
            cal.weekday          = 3'((days + 4) % 7);
            cal.day_of_year      = 9'(yday);
            return cal;
        endfunction

        function void note_input(t_esc_in w);
            pending_dates.push_back(calendar_of(w));
        endfunction

        function void field_check(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_esc_out got);
            t_esc_out want;
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            field_check("second", 32'(want.second), 32'(got.second));
            field_check("minute", 32'(want.minute), 32'(got.minute));
            field_check("hour", 32'(want.hour), 32'(got.hour));
            field_check("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
            field_check("month_index", 32'(want.month_index), 32'(got.month_index));
            field_check("years_since_1900", 32'(want.years_since_1900),
                        32'(got.years_since_1900));
            field_check("weekday", 32'(want.weekday), 32'(got.weekday));
            field_check("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
        endfunction
    endclass

    calendar_scoreboard sb = new();

    epoch_seconds_to_calendar u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in        (i_in),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_out);
        end
        if (i_rst_n && start && !busy) begin
            sb.note_input(i_in);
        end
    end

    // Hold start until the word is taken; idle at random before it
    task automatic send_word(input logic [31:0] secs, input logic local_flag,
                             input int idle_pct);
        int      gap;
        t_esc_in w;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.epoch_seconds = secs;
        w.want_local    = local_flag;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
    endtask

    // Drain every word in flight, then write the offset register
    task automatic set_zone(input logic signed [ZONE_W-1:0] minutes);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_dates.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= minutes;
        @(posedge i_clk);
        sb.zone_minutes = minutes;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_epoch();
        int unsigned days;
        int unsigned pick;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom;
            5:             return $urandom_range(0, 200000);
            6:             return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            7: begin
                days = $urandom_range(0, MAX_DAY);
                if ($urandom_range(1)) begin
                    return days * SECS_PER_DAY + $urandom_range(0, 3);
                end
                return days * SECS_PER_DAY + $urandom_range(86396, 86399);
            end
            default: begin
                // Land near leap days and year starts inside a four-year group
                case ($urandom_range(9))
                    0:       pick = 58;
                    1:       pick = 59;
                    2:       pick = 60;
                    3:       pick = 365;
                    4:       pick = 366;
                    5:       pick = 424;
                    6:       pick = 425;
                    7:       pick = 731;
                    8:       pick = 1096;
                    default: pick = 1460;
                endcase
                days = $urandom_range(1, 34) * DAYS_PER_QUAD + pick - DAYS_1968_1970;
                if (days > MAX_DAY) begin
                    days = days - DAYS_PER_QUAD;
                end
                return days * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
            end
        endcase
    endfunction

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int                       waited;
        int                       idle_pct;
        logic signed [ZONE_W-1:0] zone;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // UTC corners at the reset offset
        send_word(32'd0, 1'b0, 0);
        send_word(32'd0, 1'b1, 0);
        send_word(32'hFFFF_FFFF, 1'b0, 0);
        send_word(32'hFFFF_FFFF, 1'b1, 0);
        send_word(32'd68169600, 1'b0, 0);
        send_word(32'd946684799, 1'b0, 0);
        send_word(32'd951782400, 1'b0, 0);
        send_word(32'd951868800, 1'b0, 0);
        send_word(32'd978307199, 1'b0, 0);
        send_word(32'd4107456000, 1'b0, 0);
        send_word(32'd4107542400, 1'b0, 0);
        send_word(32'd4107628800, 1'b0, 0);

        // Wrap below zero and above the top of the count
        set_zone(-14'sd779);
        send_word(32'd0, 1'b1, 0);
        send_word(32'd59, 1'b1, 0);
        send_word(32'd46740, 1'b1, 0);
        send_word(32'd46740, 1'b0, 0);
        set_zone(14'sd779);
        send_word(32'hFFFF_FFFF, 1'b1, 0);
        send_word(32'hFFFF_4B6C, 1'b1, 0);

        // Large offsets fall back to UTC
        set_zone(14'sd780);
        send_word(32'd12345, 1'b1, 0);
        set_zone(-14'sd780);
        send_word(32'd12345, 1'b1, 0);
        set_zone(14'sd8191);
        send_word(32'd1000, 1'b1, 0);
        set_zone(-14'sd8192);
        send_word(32'd1000, 1'b1, 0);
        set_zone(14'sd5940);
        send_word(32'd0, 1'b1, 0);
        set_zone(-14'sd5940);
        send_word(32'd0, 1'b1, 0);

        for (int phase = 0; phase < 10; phase++) begin
            if ($urandom_range(3) == 0) begin
                zone = ZONE_W'($urandom_range(0, 16383));
            end else begin
                zone = ZONE_W'(int'($urandom_range(0, 1558)) - 779);
            end
            set_zone(zone);
            idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            for (int n = 0; n < 95; n++) begin
                send_word(pick_epoch(), 1'($urandom_range(1)), idle_pct);
            end
        end

        start  <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending_dates.size() != 0 && waited < 4000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.pending_dates.size() != 0) begin
            $display("%0t: %0d result words never arrived, expected %h, actual none",
                     $time, sb.pending_dates.size(), sb.pending_dates[0]);
        end
        if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- epoch_seconds_to_calendar.f -----
+incdir+sv
sv/esc_pkg.sv
sv/esc_queue.sv
sv/esc_front.sv
sv/esc_back.sv
sv/epoch_seconds_to_calendar.sv
tb/sv/tb_epoch_seconds_to_calendar.sv
